// ===== rtl/gda_pkg.sv =====
package gda_pkg;

  localparam int unsigned YEAR_W = 15;

  localparam logic [YEAR_W-1:0] YEAR_FIRST = 15'd1600;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 15'd9999;
  localparam logic [YEAR_W-1:0] MOD_DIV    = 15'd400;
  localparam logic [YEAR_W-1:0] CENT_1     = 15'd100;
  localparam logic [YEAR_W-1:0] CENT_2     = 15'd200;
  localparam logic [YEAR_W-1:0] CENT_3     = 15'd300;

  // restoring reduction of the year mod 400: divisor shifted by 5 down to 0
  localparam int unsigned MOD_STEPS = 6;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [4:0] LEN_SHORT = 5'd28;
  localparam logic [4:0] LEN_MID   = 5'd30;
  localparam logic [4:0] LEN_LONG  = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_OUT
  } state_t;

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_MID;
      MON_FEB: len = leap ? LEN_SHORT + 5'd1 : LEN_SHORT;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

  // r is the year mod 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
  endfunction

endpackage

// ===== rtl/gregorian_date_add_days_core.sv =====
// Sequence: accept, 6 year-mod-400 steps, check, a walk of one month per step (skipped
//   for an invalid date), output; a 4095-day add walks up to about 135 months.
// Throughput: one transfer at a time; in_tready is low from accept until the result
//   transfer completes. Long month walks on the shared add/subtract unit dominate that span.
// Reset: synchronous active-low rst_n returns the sequencer to idle, no result pending.
module gregorian_date_add_days_core
  import gda_pkg::*;
#(
  parameter int unsigned ADD_WIDTH = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], add_days[22+ADD_WIDTH:23]
  input  logic [((23+ADD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // end_day[4:0], end_month[8:5], end_year[22:9]
  output logic [23:0]                           out_tdata,
  // date_valid[0], year_overflow[1]
  output logic [1:0]                            out_tuser
);

  localparam int unsigned DW = ((ADD_WIDTH > 5) ? ADD_WIDTH : 5) + 1;
  localparam int unsigned SW = (DW > YEAR_W) ? DW : YEAR_W;
  localparam int unsigned KW = $clog2(MOD_STEPS);

  state_t state_r, state_nxt;

  logic [DW-1:0]        d_r, d_nxt;
  logic [3:0]           m_r, m_nxt;
  logic [YEAR_W-1:0]    y_r, y_nxt;
  logic [YEAR_W-1:0]    rem_r, rem_nxt;
  logic [ADD_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 valid_r, valid_nxt;
  logic                 ovf_r, ovf_nxt;

  // shared add/subtract unit
  logic [SW-1:0] u_a, u_b;
  logic          u_sub;
  logic [SW:0]   u_res;
  logic          u_carry;

  assign u_res   = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {{SW{1'b0}}, u_sub};
  assign u_carry = u_res[SW];

  logic [4:0] cur_len;
  logic       leap;
  logic       in_ok;
  logic       walk_gt;

  assign leap    = is_leap(rem_r);
  assign cur_len = month_length(m_r, leap);
  assign in_ok   = (y_r >= YEAR_FIRST) && (m_r >= MON_JAN) && (m_r <= MON_DEC) &&
                   (d_r != '0) && (d_r <= DW'(cur_len));
  assign walk_gt = u_carry && (u_res[SW-1:0] != '0);

  always_comb begin
    u_sub = 1'b1;
    u_a   = SW'(d_r);
    u_b   = SW'(cur_len);
    case (state_r)
      ST_MOD: begin
        u_a = SW'(rem_r);
        u_b = SW'(MOD_DIV) << k_r;
      end
      ST_CHECK: begin
        u_sub = 1'b0;
        u_b   = SW'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MOD;
      ST_MOD:   if (k_r == '0) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = in_ok ? ST_WALK : ST_OUT;
      ST_WALK:  if (!walk_gt) state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    d_nxt     = d_r;
    m_nxt     = m_r;
    y_nxt     = y_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    valid_nxt = valid_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          d_nxt   = DW'(in_tdata[4:0]);
          m_nxt   = in_tdata[8:5];
          y_nxt   = {1'b0, in_tdata[22:9]};
          rem_nxt = {1'b0, in_tdata[22:9]};
          cnt_nxt = in_tdata[22+ADD_WIDTH:23];
          k_nxt   = KW'(MOD_STEPS - 1);
        end
      end
      ST_MOD: begin
        if (u_carry) rem_nxt = u_res[YEAR_W-1:0];
        k_nxt = k_r - KW'(1);
      end
      ST_CHECK: begin
        valid_nxt = in_ok;
        ovf_nxt   = 1'b0;
        if (in_ok) d_nxt = u_res[DW-1:0];
      end
      ST_WALK: begin
        if (walk_gt) begin
          d_nxt = u_res[DW-1:0];
          if (m_r == MON_DEC) begin
            m_nxt = MON_JAN;
            y_nxt = y_r + YEAR_W'(1);
            rem_nxt = (rem_r == MOD_DIV - YEAR_W'(1)) ? '0 : rem_r + YEAR_W'(1);
          end else begin
            m_nxt = m_r + 4'd1;
          end
        end else if (y_r > YEAR_LAST) begin
          d_nxt   = DW'(LEN_LONG);
          m_nxt   = MON_DEC;
          y_nxt   = YEAR_LAST;
          ovf_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    m_r     <= m_nxt;
    y_r     <= y_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    valid_r <= valid_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {1'b0, y_r[13:0], m_r, d_r[4:0]};
  assign out_tuser  = {ovf_r, valid_r};

  a_ovf_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("overflow flagged on invalid date");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> rem_r < MOD_DIV)
    else $error("year residue out of range during walk");

  a_check_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> $past(state_r) == ST_MOD && $past(k_r) == '0)
    else $error("check entered before year reduction finished");

  a_valid_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[4:0] != 5'd0) && (out_tdata[8:5] >= MON_JAN) && (out_tdata[8:5] <= MON_DEC))
    else $error("valid result outside calendar range");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gda_pkg::*;

  localparam int unsigned ADD_W = 12;
  localparam int unsigned IN_W  = ((23 + ADD_W + 7) / 8) * 8;

  typedef struct {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [13:0]      year;
    logic [ADD_W-1:0] add;
  } date_item_t;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        valid;
    logic        ovf;
  } date_result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [23:0]     out_tdata;
  logic [1:0]      out_tuser;

  date_item_t   pending_dates[$];
  date_result_t expected_dates[$];
  date_item_t   drive_item;
  int unsigned  queued_cnt = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  checked_cnt = 0;
  int unsigned  err_cnt = 0;
  int unsigned  in_gap = 0;
  int unsigned  out_hold = 0;
  logic         no_idle = 1'b0;

  gregorian_date_add_days_core #(
    .ADD_WIDTH(ADD_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return leap_year(y) ? 29 : 28;
    return 31;
  endfunction

  function automatic date_result_t predict_end_date(date_item_t it);
    date_result_t r;
    int unsigned d, m, y;
    d = it.day;
    m = it.month;
    y = it.year;
    r.valid = (y >= 1600) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in_month(m, y));
    r.ovf = 1'b0;
    if (r.valid) begin
      d = d + it.add;
      while (d > days_in_month(m, y)) begin
        d = d - days_in_month(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      if (y > 9999) begin
        d = 31;
        m = 12;
        y = 9999;
        r.ovf = 1'b1;
      end
    end
    r.day = d[4:0];
    r.month = m[3:0];
    r.year = y[13:0];
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t on result %0d: %s got %0d want %0d",
             $realtime, checked_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic queue_date(int unsigned d, int unsigned m, int unsigned y, int unsigned n);
    date_item_t it;
    it.day = d[4:0];
    it.month = m[3:0];
    it.year = y[13:0];
    it.add = n[ADD_W-1:0];
    pending_dates.push_back(it);
    queued_cnt++;
  endtask

  task automatic queue_random_date();
    int unsigned kind, d, m, y, n;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 62) : $urandom_range(0, 4095);
    case ($urandom_range(0, 3))
      0: y = $urandom_range(1600, 1610);
      1: y = $urandom_range(9985, 9999);
      default: y = $urandom_range(1600, 9999);
    endcase
    if (kind >= 70 && kind < 80) y = $urandom_range(9988, 9999);
    else if (kind >= 80 && kind < 88) y = $urandom_range(10000, 16383);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, days_in_month(m, y));
    if (kind >= 88) begin
      case ($urandom_range(0, 4))
        0: d = 0;
        1: d = $urandom_range(days_in_month(m, y) + 1, 31);
        2: m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
        3: y = $urandom_range(0, 1599);
        default: begin
          d = $urandom_range(0, 31);
          m = $urandom_range(0, 15);
          y = $urandom_range(0, 16383);
        end
      endcase
    end
    queue_date(d, m, y, n);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_cnt != queued_cnt || checked_cnt != accepted_cnt);
  endtask

  always @(posedge clk) begin : drv
    date_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= draw_gap();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(predict_end_date(drive_item));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_dates.size() != 0) begin
          it = pending_dates.pop_front();
          drive_item <= it;
          in_tdata <= {{(IN_W-23-ADD_W){1'b0}}, it.add, it.year, it.month, it.day};
          in_tvalid <= 1'b1;
          in_gap <= draw_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    date_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= draw_gap();
    end else if (out_tvalid && out_tready) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected transfer, tdata", out_tdata, 0);
      end else begin
        want = expected_dates.pop_front();
        if (out_tdata[4:0] !== want.day) report_mismatch("end_day", out_tdata[4:0], want.day);
        if (out_tdata[8:5] !== want.month)
          report_mismatch("end_month", out_tdata[8:5], want.month);
        if (out_tdata[22:9] !== want.year)
          report_mismatch("end_year", out_tdata[22:9], want.year);
        if (out_tuser[0] !== want.valid)
          report_mismatch("date_valid", out_tuser[0], want.valid);
        if (out_tuser[1] !== want.ovf)
          report_mismatch("year_overflow", out_tuser[1], want.ovf);
      end
      checked_cnt <= checked_cnt + 1;
      out_tready <= 1'b0;
      out_hold <= draw_gap();
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    queue_date(1, 1, 1600, 0);
    queue_date(31, 12, 9999, 0);
    queue_date(31, 12, 9999, 1);
    queue_date(28, 2, 2000, 1);
    queue_date(28, 2, 1900, 1);
    queue_date(28, 2, 2024, 1);
    queue_date(29, 2, 2023, 0);
    queue_date(29, 2, 1600, 4095);
    queue_date(30, 4, 2021, 1);
    queue_date(31, 4, 2021, 3);
    queue_date(0, 5, 2000, 7);
    queue_date(15, 0, 2000, 7);
    queue_date(15, 13, 2000, 7);
    queue_date(31, 15, 16383, 4095);
    queue_date(1, 1, 1599, 10);
    queue_date(31, 12, 1599, 1);
    queue_date(1, 1, 16383, 0);
    queue_date(31, 12, 9989, 4095);
    queue_date(1, 1, 9988, 4095);
    queue_date(31, 1, 2001, 28);
    queue_date(31, 12, 2099, 1);
    queue_date(29, 2, 2100, 1);
    queue_date(29, 2, 2400, 365);
    wait_drained();

    // settle fully before the random phases, then vary the idling
    repeat (800) queue_random_date();
    wait_drained();
    no_idle = 1'b1;
    repeat (300) queue_random_date();
    wait_drained();
    no_idle = 1'b0;
    repeat (550) queue_random_date();
    wait_drained();

    repeat (160) @(posedge clk);
    if (err_cnt == 0 && expected_dates.size() == 0) begin
      $display("gregorian_date_add_days_core regression: pass");
    end else begin
      $display("gregorian_date_add_days_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("gregorian_date_add_days_core regression: fail");
    $finish;
  end

endmodule
